@@ sv/x2apic_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package x2apic_pkg;

  // msr numbers
  localparam logic [31:0] MSR_APIC_FIRST = 32'h0000_0802;
  localparam logic [31:0] MSR_APIC_END   = 32'h0000_083F;
  localparam logic [31:0] MSR_ICR        = 32'h0000_0830;
  localparam logic [31:0] MSR_TIMER_LVT  = 32'h0000_0832;
  localparam logic [31:0] MSR_INIT_COUNT = 32'h0000_0838;
  localparam logic [31:0] MSR_DIVIDE     = 32'h0000_083E;
  localparam logic [31:0] MSR_POWER_UNIT = 32'h0000_0606;
  localparam logic [31:0] DEST_ALL_ONES  = 32'hFFFF_FFFF;

  // register file offsets (window offsets all sit below 0x40)
  localparam int          OFF_W          = 6;
  localparam logic [5:0]  OFF_ICR_LO     = 6'h30;
  localparam logic [5:0]  OFF_ICR_HI     = 6'h31;
  localparam logic [5:0]  OFF_LVT        = 6'h32;
  localparam logic [5:0]  OFF_INIT       = 6'h38;
  localparam logic [5:0]  OFF_CUR        = 6'h39;
  localparam logic [5:0]  OFF_DIV        = 6'h3E;

  // icr fields
  localparam logic [2:0]  MODE_FIXED     = 3'd0;
  localparam logic [2:0]  MODE_INIT      = 3'd5;
  localparam logic [1:0]  SH_NONE        = 2'd0;
  localparam logic [1:0]  SH_SELF        = 2'd1;
  localparam logic [1:0]  SH_ALL_INCL    = 2'd2;
  localparam logic [1:0]  SH_ALL_EXCL    = 2'd3;

  // configuration register indexes
  localparam logic        CFG_CORE_COUNT = 1'b0;
  localparam logic        CFG_OWN_CORE   = 1'b1;

  localparam logic        CMD_READ       = 1'b0;
  localparam logic        CMD_WRITE      = 1'b1;
  localparam logic        KIND_DONE      = 1'b0;
  localparam logic        KIND_IRQ       = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ICR_HI,
    ST_DELIV,
    ST_TCUR,
    ST_CMPL
  } state_e;

  // timer view handed to the sequencer
  typedef struct packed {
    logic        armed;
    logic [31:0] period;
    logic [31:0] count;
  } timer_status_t;

  // one result word
  typedef struct packed {
    logic        kind;
    logic [31:0] read_low;
    logic [31:0] read_high;
    logic        status;
    logic [3:0]  target_core;
    logic [7:0]  irq_vector;
    logic        timer_update;
    logic        timer_armed;
    logic [31:0] timer_period;
    logic        last;
  } out_word_t;

endpackage

`default_nettype wire

@@ sv/x2apic_timer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module x2apic_timer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_i,
  input  logic [5:0]               off_i,
  input  logic [31:0]              data_i,
  output x2apic_pkg::timer_status_t status_o
);
  import x2apic_pkg::*;

  logic [7:0]  vec_q;
  logic [31:0] init_q;
  logic [2:0]  div_q;
  logic [2:0]  shift;

  // copies of the lvt vector, initial count and divide fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q  <= '0;
      init_q <= '0;
      div_q  <= '0;
    end else if (wr_i) begin
      if (off_i == OFF_LVT)  vec_q  <= data_i[7:0];
      if (off_i == OFF_INIT) init_q <= data_i;
      if (off_i == OFF_DIV)  div_q  <= {data_i[3], data_i[1:0]};
    end
  end

  // divide shift wraps at eight
  assign shift = div_q + 3'd1;

  always_comb begin
    status_o.armed  = (vec_q != '0) && (init_q != '0);
    status_o.period = status_o.armed ? (init_q << shift) : '0;
    status_o.count  = init_q;
  end

endmodule

`default_nettype wire

@@ sv/x2apic_msr_register_block.sv @@
`timescale 1ns / 1ps
`default_nettype none

// The register file is read at the accepting edge; a read's completion word is then
// registered from ST_EXEC once the output register is free. One access at a time:
// an icr write stores its halves in ST_EXEC and ST_ICR_HI and, in fixed mode,
// emits deliveries in ST_DELIV; a broadcast scans each core slot below the count.
// The register file has one write port, so the two icr halves go in separate states.
// Reset: the 64 per-entry valid bits clear at once, no clearing pass is needed.
module x2apic_msr_register_block #(
  parameter int MAX_CORES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_cmd_i,
  input  logic [31:0] in_msr_address_i,
  input  logic [31:0] in_write_low_i,
  input  logic [31:0] in_write_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [31:0] out_read_low_o,
  output logic [31:0] out_read_high_o,
  output logic        out_status_o,
  output logic [3:0]  out_target_core_o,
  output logic [7:0]  out_irq_vector_o,
  output logic        out_timer_update_o,
  output logic        out_timer_armed_o,
  output logic [31:0] out_timer_period_o,
  output logic        out_last_o
);
  import x2apic_pkg::*;

  localparam int          CapCores = (MAX_CORES < 16) ? MAX_CORES : 16;
  localparam logic [4:0]  CORE_CAP = 5'(CapCores);
  localparam int          Depth    = 1 << OFF_W;

  // configuration
  logic [4:0] core_count_q;
  logic [3:0] own_core_q;
  logic [4:0] eff_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_count_q <= 5'd16;
      own_core_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CORE_COUNT: core_count_q <= cfg_data_i;
        CFG_OWN_CORE:   own_core_q   <= cfg_data_i[3:0];
        default:        ;
      endcase
    end
  end

  assign eff_cnt = (core_count_q > CORE_CAP) ? CORE_CAP : core_count_q;

  // sequencer state
  state_e      state_q, state_d;
  logic        cmd_q;
  logic [31:0] addr_q, lo_q, hi_q;
  logic [4:0]  idx_q, idx_d;
  logic        st_q, st_d;
  logic        in_accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= in_cmd_i;
      addr_q <= in_msr_address_i;
      lo_q   <= in_write_low_i;
      hi_q   <= in_write_high_i;
    end
  end

  // register file with per-entry valid bits, two registered read ports
  logic [31:0]      mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [31:0]      rd_a_q, rd_b_q;
  logic             rd_a_vld_q, rd_b_vld_q;
  logic             mem_we;
  logic [OFF_W-1:0] mem_addr;
  logic [31:0]      mem_wdata;
  logic [OFF_W-1:0] rd_addr;

  assign rd_addr = in_msr_address_i[OFF_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (in_accept) begin
      rd_a_q <= mem[rd_addr];
      rd_b_q <= mem[OFF_ICR_HI];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[mem_addr] <= 1'b1;
      if (in_accept) begin
        rd_a_vld_q <= vld_q[rd_addr];
        rd_b_vld_q <= vld_q[OFF_ICR_HI];
      end
    end
  end

  // timer shadow
  logic          tmr_we;
  timer_status_t tmr;

  x2apic_timer u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tmr_we),
    .off_i    (addr_q[OFF_W-1:0]),
    .data_i   (lo_q),
    .status_o (tmr)
  );

  // access decode
  logic       in_window, is_icr, is_timer, icr_bad;
  logic       dst_ones, all_dst, self_dst;
  logic [1:0] sh;
  logic [2:0] mode;

  assign in_window = (addr_q >= MSR_APIC_FIRST) && (addr_q < MSR_APIC_END);
  assign is_icr    = (addr_q == MSR_ICR);
  assign is_timer  = (addr_q == MSR_TIMER_LVT) || (addr_q == MSR_INIT_COUNT) ||
                     (addr_q == MSR_DIVIDE);
  assign sh        = lo_q[19:18];
  assign mode      = lo_q[10:8];
  assign dst_ones  = (hi_q == DEST_ALL_ONES);
  assign all_dst   = (sh == SH_ALL_INCL) || (sh == SH_ALL_EXCL) || dst_ones;
  assign self_dst  = (sh == SH_SELF) || (sh == SH_ALL_INCL) || dst_ones;
  assign icr_bad   = lo_q[11] ||
                     ((hi_q >= {27'd0, eff_cnt}) && !(self_dst && all_dst));

  // output register
  out_word_t out_q, out_d;
  logic      out_valid_q;
  logic      out_free, out_load;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  // next state, memory writes and result words
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    st_d      = st_q;
    mem_we    = 1'b0;
    mem_addr  = addr_q[OFF_W-1:0];
    mem_wdata = lo_q;
    tmr_we    = 1'b0;
    out_load  = 1'b0;
    out_d     = '0;
    out_d.last = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        st_d = 1'b0;
        if (in_window && cmd_q == CMD_READ) begin
          // read completion straight from the registered read data
          out_d.read_low  = rd_a_vld_q ? rd_a_q : '0;
          out_d.read_high = (is_icr && rd_b_vld_q) ? rd_b_q : '0;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (in_window && is_icr) begin
          if (icr_bad) begin
            st_d    = 1'b1;
            state_d = ST_CMPL;
          end else begin
            mem_we   = 1'b1;
            mem_addr = OFF_ICR_LO;
            state_d  = ST_ICR_HI;
          end
        end else if (in_window && is_timer) begin
          mem_we  = 1'b1;
          tmr_we  = 1'b1;
          state_d = ST_TCUR;
        end else if (in_window) begin
          mem_we  = 1'b1;
          state_d = ST_CMPL;
        end else begin
          st_d    = !((addr_q == MSR_POWER_UNIT) && cmd_q == CMD_READ);
          state_d = ST_CMPL;
        end
      end
      ST_ICR_HI: begin
        mem_we    = 1'b1;
        mem_addr  = OFF_ICR_HI;
        mem_wdata = hi_q;
        idx_d     = '0;
        state_d   = (mode == MODE_FIXED) ? ST_DELIV : ST_CMPL;
      end
      ST_DELIV: begin
        out_d.kind       = KIND_IRQ;
        out_d.last       = 1'b0;
        out_d.irq_vector = lo_q[7:0];
        if (all_dst) begin
          // scan every core slot, skipping self when excluded
          out_d.target_core = idx_q[3:0];
          if (idx_q >= eff_cnt) begin
            state_d = ST_CMPL;
          end else if (idx_q == {1'b0, own_core_q} && !self_dst) begin
            idx_d = idx_q + 5'd1;
          end else if (out_free) begin
            out_load = 1'b1;
            idx_d    = idx_q + 5'd1;
          end
        end else begin
          out_d.target_core = self_dst ? own_core_q : hi_q[3:0];
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_CMPL;
          end
        end
      end
      ST_TCUR: begin
        // current count follows the initial count
        mem_we             = 1'b1;
        mem_addr           = OFF_CUR;
        mem_wdata          = tmr.count;
        out_d.timer_update = 1'b1;
        out_d.timer_armed  = tmr.armed;
        out_d.timer_period = tmr.period;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_CMPL: begin
        out_d.status = st_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      st_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      st_q    <= st_d;
    end
  end

  // ports
  assign out_valid_o        = out_valid_q;
  assign out_kind_o         = out_q.kind;
  assign out_read_low_o     = out_q.read_low;
  assign out_read_high_o    = out_q.read_high;
  assign out_status_o       = out_q.status;
  assign out_target_core_o  = out_q.target_core;
  assign out_irq_vector_o   = out_q.irq_vector;
  assign out_timer_update_o = out_q.timer_update;
  assign out_timer_armed_o  = out_q.timer_armed;
  assign out_timer_period_o = out_q.timer_period;
  assign out_last_o         = out_q.last;

`ifndef SYNTHESIS
  // an accepted word is always decoded in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_EXEC)
    else $error("accepted word not decoded next cycle");

  // the register file is never written while a new word may be read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q != ST_IDLE)
    else $error("register file written while idle");

  // a held result word is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("stalled result word overwritten");

  // the broadcast scan never runs past the core count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELIV && all_dst) |-> idx_q <= eff_cnt)
    else $error("broadcast index beyond core count");
`endif

endmodule

`default_nettype wire
